/* hw/rtl/tcc_pkg.sv */
package tcc_pkg;

    // Number of second-level products feeding the two numerators.
    localparam int NPROD = 10;

    // Product slots.
    localparam int PX3P3 = 0;
    localparam int PX2P2 = 1;
    localparam int PX1P1 = 2;
    localparam int PQD31 = 3;
    localparam int PX3E3 = 4;
    localparam int PX2E2 = 5;
    localparam int PX1E1 = 6;
    localparam int PP3S  = 7;
    localparam int PP2S  = 8;
    localparam int PP1S  = 9;

    // Control travelling alongside the divider cells.
    typedef struct packed {
        logic valid;
        logic degen;
        logic neg_x;
        logic neg_y;
    } tcc_flags_t;

endpackage

/* hw/rtl/tcc_div_cell.sv */
// One restoring step per cell, x and y lanes sharing the divisor.
module tcc_div_cell #(
    parameter int MW = 61,
    parameter int DW = 36
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  tcc_pkg::tcc_flags_t flags_in,
    input  logic [DW-1:0]       div_in,
    input  logic [DW-1:0]       rem_x_in,
    input  logic [MW-1:0]       wrd_x_in,
    input  logic [DW-1:0]       rem_y_in,
    input  logic [MW-1:0]       wrd_y_in,
    output tcc_pkg::tcc_flags_t flags_out,
    output logic [DW-1:0]       div_out,
    output logic [DW-1:0]       rem_x_out,
    output logic [MW-1:0]       wrd_x_out,
    output logic [DW-1:0]       rem_y_out,
    output logic [MW-1:0]       wrd_y_out
);

    tcc_pkg::tcc_flags_t flags_reg;
    logic [DW-1:0] div_reg, rem_x_reg, rem_y_reg;
    logic [MW-1:0] wrd_x_reg, wrd_y_reg;
    logic [DW-1:0] rem_x_next, rem_y_next;
    logic [MW-1:0] wrd_x_next, wrd_y_next;
    logic [DW:0]   tx, ty, dv, sx, sy;

    always_comb begin
        dv = {1'b0, div_in};
        tx = {rem_x_in, wrd_x_in[MW-1]};
        ty = {rem_y_in, wrd_y_in[MW-1]};
        sx = tx - dv;
        sy = ty - dv;
        // dividend bits leave at the top, quotient bits enter at the bottom
        if (tx >= dv) begin
            rem_x_next = sx[DW-1:0];
            wrd_x_next = {wrd_x_in[MW-2:0], 1'b1};
        end else begin
            rem_x_next = tx[DW-1:0];
            wrd_x_next = {wrd_x_in[MW-2:0], 1'b0};
        end
        if (ty >= dv) begin
            rem_y_next = sy[DW-1:0];
            wrd_y_next = {wrd_y_in[MW-2:0], 1'b1};
        end else begin
            rem_y_next = ty[DW-1:0];
            wrd_y_next = {wrd_y_in[MW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (en) begin
            flags_reg <= flags_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg   <= div_in;
            rem_x_reg <= rem_x_next;
            wrd_x_reg <= wrd_x_next;
            rem_y_reg <= rem_y_next;
            wrd_y_reg <= wrd_y_next;
        end
    end

    assign flags_out = flags_reg;
    assign div_out   = div_reg;
    assign rem_x_out = rem_x_reg;
    assign wrd_x_out = wrd_x_reg;
    assign rem_y_out = rem_y_reg;
    assign wrd_y_out = wrd_y_reg;

endmodule

/* hw/rtl/triangle_circumcenter.sv */
// Pipeline: 7 arithmetic stages, one divider cell per quotient bit, then the output register.
// Throughput: one triangle per cycle unless m_tready stalls the output, set by the fully
//   pipelined multiplier stages and the row of divider cells, each retiring one quotient bit
//   of both coordinates per cycle.
// Reset: aresetn synchronous, active low; clears all valid bits and the output skid.
module triangle_circumcenter #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y (16 each)
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // center_x [31:0], center_y [63:32]
    output logic [63:0] m_tdata,
    // degenerate [0], saturated [1]
    output logic [1:0]  m_tuser
);

    localparam int C    = COORD_BITS;
    localparam int DFW  = C + 1;          // coordinate differences and sums
    localparam int PW   = 2 * C + 1;      // first-level products
    localparam int WW   = 2 * C + 2;      // wide operand of second-level products
    localparam int L    = C + 1;          // split point of the wide operand
    localparam int NW   = 3 * C + 4;      // numerators
    localparam int DENW = 2 * C + 4;      // denominator
    localparam int DW   = 2 * C + 4;      // divisor 2*|den|
    localparam int MW   = 3 * C + FRAC_BITS + 5; // dividend / quotient
    localparam int QW   = (MW > 33) ? MW : 33;
    localparam int NP   = tcc_pkg::NPROD;

    logic en;

    // ---------------- stage 1: sign extension, differences, sums
    logic [C+15:0] ext [6];
    logic signed [C-1:0] crd [6];
    logic [7:1] vld_reg;

    logic signed [C-1:0]   s1_x1_reg, s1_x2_reg, s1_x3_reg;
    logic signed [DFW-1:0] s1_d12_reg, s1_d31_reg, s1_d23_reg;
    logic signed [DFW-1:0] s1_sy21_reg, s1_sy13_reg, s1_sy32_reg;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            // fields wider than COORD_BITS are ignored above it; narrower ones zero-fill
            ext[i] = {{C{1'b0}}, s_tdata[16*i +: 16]};
            crd[i] = $signed(ext[i][C-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:1], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x1_reg   <= crd[0];
            s1_x2_reg   <= crd[2];
            s1_x3_reg   <= crd[4];
            s1_d12_reg  <= DFW'(crd[3]) - DFW'(crd[1]);
            s1_d31_reg  <= DFW'(crd[1]) - DFW'(crd[5]);
            s1_d23_reg  <= DFW'(crd[5]) - DFW'(crd[3]);
            s1_sy21_reg <= DFW'(crd[3]) + DFW'(crd[1]);
            s1_sy13_reg <= DFW'(crd[1]) + DFW'(crd[5]);
            s1_sy32_reg <= DFW'(crd[5]) + DFW'(crd[3]);
        end
    end

    // ---------------- stage 2: first-level products
    logic signed [PW-1:0]  s2_p1_reg, s2_p2_reg, s2_p3_reg;
    logic signed [PW-1:0]  s2_s1_reg, s2_s2_reg, s2_s3_reg;
    logic signed [WW-1:0]  s2_q_reg;
    logic signed [C-1:0]   s2_x1_reg, s2_x2_reg, s2_x3_reg;
    logic signed [DFW-1:0] s2_d31_reg, s2_sy21_reg, s2_sy13_reg, s2_sy32_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_p3_reg   <= s1_x3_reg * s1_d12_reg;
            s2_p2_reg   <= s1_x2_reg * s1_d31_reg;
            s2_p1_reg   <= s1_x1_reg * s1_d23_reg;
            s2_s1_reg   <= s1_x1_reg * s1_x1_reg;
            s2_s2_reg   <= s1_x2_reg * s1_x2_reg;
            s2_s3_reg   <= s1_x3_reg * s1_x3_reg;
            s2_q_reg    <= s1_d12_reg * s1_d23_reg;
            s2_x1_reg   <= s1_x1_reg;
            s2_x2_reg   <= s1_x2_reg;
            s2_x3_reg   <= s1_x3_reg;
            s2_d31_reg  <= s1_d31_reg;
            s2_sy21_reg <= s1_sy21_reg;
            s2_sy13_reg <= s1_sy13_reg;
            s2_sy32_reg <= s1_sy32_reg;
        end
    end

    // ---------------- stage 3: denominator, square differences
    logic signed [DENW-1:0] s3_den_reg;
    logic signed [PW-1:0]   s3_e1_reg, s3_e2_reg, s3_e3_reg;
    logic signed [PW-1:0]   s3_p1_reg, s3_p2_reg, s3_p3_reg;
    logic signed [WW-1:0]   s3_q_reg;
    logic signed [C-1:0]    s3_x1_reg, s3_x2_reg, s3_x3_reg;
    logic signed [DFW-1:0]  s3_d31_reg, s3_sy21_reg, s3_sy13_reg, s3_sy32_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_den_reg  <= (DENW'(s2_p3_reg) + DENW'(s2_p2_reg) + DENW'(s2_p1_reg)) <<< 1;
            s3_e3_reg   <= s2_s2_reg - s2_s1_reg;
            s3_e2_reg   <= s2_s1_reg - s2_s3_reg;
            s3_e1_reg   <= s2_s3_reg - s2_s2_reg;
            s3_p1_reg   <= s2_p1_reg;
            s3_p2_reg   <= s2_p2_reg;
            s3_p3_reg   <= s2_p3_reg;
            s3_q_reg    <= s2_q_reg;
            s3_x1_reg   <= s2_x1_reg;
            s3_x2_reg   <= s2_x2_reg;
            s3_x3_reg   <= s2_x3_reg;
            s3_d31_reg  <= s2_d31_reg;
            s3_sy21_reg <= s2_sy21_reg;
            s3_sy13_reg <= s2_sy13_reg;
            s3_sy32_reg <= s2_sy32_reg;
        end
    end

    // ---------------- stage 4: partial products, wide operand split in two
    logic signed [DFW-1:0] na [NP];
    logic signed [WW-1:0]  wb [NP];
    logic signed [2*C+2:0] s4_lo_reg [NP];
    logic signed [2*C+1:0] s4_hi_reg [NP];
    logic signed [DENW-1:0] s4_den_reg;

    always_comb begin
        na[tcc_pkg::PX3P3] = DFW'(s3_x3_reg);   wb[tcc_pkg::PX3P3] = WW'(s3_p3_reg);
        na[tcc_pkg::PX2P2] = DFW'(s3_x2_reg);   wb[tcc_pkg::PX2P2] = WW'(s3_p2_reg);
        na[tcc_pkg::PX1P1] = DFW'(s3_x1_reg);   wb[tcc_pkg::PX1P1] = WW'(s3_p1_reg);
        na[tcc_pkg::PQD31] = s3_d31_reg;        wb[tcc_pkg::PQD31] = s3_q_reg;
        na[tcc_pkg::PX3E3] = DFW'(s3_x3_reg);   wb[tcc_pkg::PX3E3] = WW'(s3_e3_reg);
        na[tcc_pkg::PX2E2] = DFW'(s3_x2_reg);   wb[tcc_pkg::PX2E2] = WW'(s3_e2_reg);
        na[tcc_pkg::PX1E1] = DFW'(s3_x1_reg);   wb[tcc_pkg::PX1E1] = WW'(s3_e1_reg);
        na[tcc_pkg::PP3S]  = s3_sy21_reg;       wb[tcc_pkg::PP3S]  = WW'(s3_p3_reg);
        na[tcc_pkg::PP2S]  = s3_sy13_reg;       wb[tcc_pkg::PP2S]  = WW'(s3_p2_reg);
        na[tcc_pkg::PP1S]  = s3_sy32_reg;       wb[tcc_pkg::PP1S]  = WW'(s3_p1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NP; k++) begin
                s4_lo_reg[k] <= na[k] * $signed({1'b0, wb[k][L-1:0]});
                s4_hi_reg[k] <= na[k] * $signed(wb[k][WW-1:L]);
            end
            s4_den_reg <= s3_den_reg;
        end
    end

    // ---------------- stage 5: recombine partials
    logic signed [NW-1:0]   s5_prod_reg [NP];
    logic signed [DENW-1:0] s5_den_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NP; k++) begin
                s5_prod_reg[k] <= (NW'(s4_hi_reg[k]) <<< L) + NW'(s4_lo_reg[k]);
            end
            s5_den_reg <= s4_den_reg;
        end
    end

    // ---------------- stage 6: numerators
    logic signed [NW-1:0]   s6_xn_reg, s6_yn_reg;
    logic signed [DENW-1:0] s6_den_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_xn_reg <= s5_prod_reg[tcc_pkg::PX3P3] + s5_prod_reg[tcc_pkg::PX2P2]
                       + s5_prod_reg[tcc_pkg::PX1P1] - s5_prod_reg[tcc_pkg::PQD31];
            s6_yn_reg <= s5_prod_reg[tcc_pkg::PX3E3] + s5_prod_reg[tcc_pkg::PX2E2]
                       + s5_prod_reg[tcc_pkg::PX1E1] + s5_prod_reg[tcc_pkg::PP3S]
                       + s5_prod_reg[tcc_pkg::PP2S]  + s5_prod_reg[tcc_pkg::PP1S];
            s6_den_reg <= s5_den_reg;
        end
    end

    // ---------------- stage 7: signs, magnitudes, rounding offset
    logic [NW-1:0]   mag_x, mag_y;
    logic [DENW-1:0] mag_d;
    tcc_pkg::tcc_flags_t s7_flags;
    logic [MW-1:0] s7_wx_reg, s7_wy_reg;
    logic [DW-1:0] s7_div_reg;
    logic s7_degen_reg, s7_negx_reg, s7_negy_reg;

    always_comb begin
        mag_x = s6_xn_reg[NW-1] ? NW'(-s6_xn_reg) : NW'(s6_xn_reg);
        mag_y = s6_yn_reg[NW-1] ? NW'(-s6_yn_reg) : NW'(s6_yn_reg);
        mag_d = s6_den_reg[DENW-1] ? DENW'(-s6_den_reg) : DENW'(s6_den_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // (|num| * 2^(F+1) + |den|) / (2|den|) rounds half away from zero
            s7_wx_reg    <= (MW'(mag_x) << (FRAC_BITS + 1)) + MW'(mag_d);
            s7_wy_reg    <= (MW'(mag_y) << (FRAC_BITS + 1)) + MW'(mag_d);
            s7_div_reg   <= DW'(mag_d) << 1;
            s7_degen_reg <= (s6_den_reg == '0);
            s7_negx_reg  <= s6_xn_reg[NW-1] ^ s6_den_reg[DENW-1];
            s7_negy_reg  <= s6_yn_reg[NW-1] ^ s6_den_reg[DENW-1];
        end
    end

    assign s7_flags = '{valid: vld_reg[7], degen: s7_degen_reg,
                        neg_x: s7_negx_reg, neg_y: s7_negy_reg};

    // ---------------- divider: one cell per quotient bit
    tcc_pkg::tcc_flags_t cf [MW+1];
    logic [DW-1:0] cd  [MW+1];
    logic [DW-1:0] crx [MW+1];
    logic [DW-1:0] cry [MW+1];
    logic [MW-1:0] cwx [MW+1];
    logic [MW-1:0] cwy [MW+1];

    assign cf[0]  = s7_flags;
    assign cd[0]  = s7_div_reg;
    assign crx[0] = '0;
    assign cry[0] = '0;
    assign cwx[0] = s7_wx_reg;
    assign cwy[0] = s7_wy_reg;

    for (genvar g = 0; g < MW; g++) begin : g_cell
        tcc_div_cell #(.MW(MW), .DW(DW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .flags_in  (cf[g]),
            .div_in    (cd[g]),
            .rem_x_in  (crx[g]),
            .wrd_x_in  (cwx[g]),
            .rem_y_in  (cry[g]),
            .wrd_y_in  (cwy[g]),
            .flags_out (cf[g+1]),
            .div_out   (cd[g+1]),
            .rem_x_out (crx[g+1]),
            .wrd_x_out (cwx[g+1]),
            .rem_y_out (cry[g+1]),
            .wrd_y_out (cwy[g+1])
        );
    end

    // ---------------- saturation, sign, degenerate override
    tcc_pkg::tcc_flags_t fin;
    logic [QW-1:0] qx, qy, limx, limy;
    logic [31:0]   vx, vy, res_x, res_y;
    logic          satx, saty, res_sat;

    always_comb begin
        fin  = cf[MW];
        qx   = QW'(cwx[MW]);
        qy   = QW'(cwy[MW]);
        limx = fin.neg_x ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
        limy = fin.neg_y ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
        satx = (qx > limx);
        saty = (qy > limy);
        vx   = satx ? limx[31:0] : qx[31:0];
        vy   = saty ? limy[31:0] : qy[31:0];
        if (fin.degen) begin
            res_x   = '0;
            res_y   = '0;
            res_sat = 1'b0;
        end else begin
            res_x   = fin.neg_x ? (32'd0 - vx) : vx;
            res_y   = fin.neg_y ? (32'd0 - vy) : vy;
            res_sat = satx | saty;
        end
    end

    // ---------------- output register plus skid word
    logic        m_valid_reg, skid_valid_reg;
    logic [63:0] m_data_reg, skid_data_reg;
    logic [1:0]  m_user_reg, skid_user_reg;
    logic        take;

    // pipeline moves whenever the skid word is free
    assign en   = !skid_valid_reg;
    assign take = en && fin.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg    <= skid_valid_reg || take;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end else begin
                m_data_reg <= {res_y, res_x};
                m_user_reg <= {res_sat, fin.degen};
            end
        end else if (take) begin
            skid_data_reg <= {res_y, res_x};
            skid_user_reg <= {res_sat, fin.degen};
        end
    end

    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---------------- checks
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0 && !m_tuser[1]))
        else $error("degenerate word with nonzero center or saturation");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word held while output empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

endmodule

/* verif/triangle_circumcenter_tb.sv */
`timescale 1ns / 1ps

module triangle_circumcenter_tb;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    // arithmetic stages, divider cells and output register of the block
    localparam int PIPE_LAT   = 8 + 3 * COORD_BITS + FRAC_BITS + 5;
    localparam int WDOG_LIMIT = 4000;
    localparam int N_RANDOM   = 930;

    typedef struct packed {
        logic        saturated;
        logic        degenerate;
        logic [31:0] center_y;
        logic [31:0] center_x;
    } center_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // a_x, a_y, b_x, b_y, c_x, c_y (16 each, lowest first)
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // center_x, center_y
    logic [1:0]  m_tuser;   // degenerate, saturated

    int n_errors;
    int idle_cycles;
    bit quiet;              // no idling in the last stretch

    triangle_circumcenter #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // rounded num * 2^FRAC / den, ties away from zero, clamped to 32 bits
    function automatic logic [31:0] fix_quotient(input logic signed [127:0] num,
                                                 input logic signed [127:0] den,
                                                 inout logic sat);
        logic neg;
        logic [127:0] mag_n, mag_d, q, lim;
        neg   = (num < 0) != (den < 0);
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        q     = ((mag_n << (FRAC_BITS + 1)) + mag_d) / (2 * mag_d);
        lim   = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
            sat = 1'b1;
            q   = lim;
        end
        if (neg) q = -q;
        return q[31:0];
    endfunction

    function automatic center_t predict_center(input logic [95:0] tri_word);
        logic signed [127:0] x1, y1, x2, y2, x3, y3;
        logic signed [127:0] d12, d31, d23, p3, p2, p1, s1, s2, s3, den, xn, yn;
        center_t r;
        logic sat;
        x1  = $signed(tri_word[COORD_BITS-1:0]);
        y1  = $signed(tri_word[16+:COORD_BITS]);
        x2  = $signed(tri_word[32+:COORD_BITS]);
        y2  = $signed(tri_word[48+:COORD_BITS]);
        x3  = $signed(tri_word[64+:COORD_BITS]);
        y3  = $signed(tri_word[80+:COORD_BITS]);
        d12 = y2 - y1;
        d31 = y1 - y3;
        d23 = y3 - y2;
        p3  = x3 * d12;
        p2  = x2 * d31;
        p1  = x1 * d23;
        s1  = x1 * x1;
        s2  = x2 * x2;
        s3  = x3 * x3;
        den = 2 * (p3 + p2 + p1);
        r   = '0;
        sat = 1'b0;
        if (den == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        xn = x3 * p3 + x2 * p2 + x1 * p1 - d12 * d23 * d31;
        yn = x3 * (s2 - s1) + x2 * (s1 - s3) + x1 * (s3 - s2)
           + p3 * (y2 + y1) + p2 * (y1 + y3) + p1 * (y3 + y2);
        r.center_x  = fix_quotient(xn, den, sat);
        r.center_y  = fix_quotient(yn, den, sat);
        r.saturated = sat;
        return r;
    endfunction

    class center_scoreboard;
        center_t pending[$];

        function void note_triangle(logic [95:0] tri_word);
            pending.push_back(predict_center(tri_word));
        endfunction

        task check_center(logic [63:0] data, logic [1:0] user);
            center_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h/%b", data, user));
                return;
            end
            want = pending.pop_front();
            if (data[31:0] !== want.center_x)
                report_mismatch($sformatf("center_x %h want %h", data[31:0], want.center_x));
            if (data[63:32] !== want.center_y)
                report_mismatch($sformatf("center_y %h want %h", data[63:32], want.center_y));
            if (user[0] !== want.degenerate)
                report_mismatch($sformatf("degenerate %b want %b", user[0], want.degenerate));
            if (user[1] !== want.saturated)
                report_mismatch($sformatf("saturated %b want %b", user[1], want.saturated));
        endtask
    endclass

    center_scoreboard sb = new();

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // accept monitor and watchdog on rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_triangle(s_tdata);
            if (m_tvalid && m_tready) sb.check_center(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side: random stall bursts
    initial begin
        int burst;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 17);
                m_tready <= 1'b0;
                repeat (burst) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // one triangle: hold tdata until accepted
    task automatic send_triangle(input logic [95:0] tri_word);
        int burst;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (burst) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tri_word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [95:0] pack_tri(input logic [15:0] ax, ay, bx, by, cx, cy);
        return {cy, cx, by, bx, ay, ax};
    endfunction

    initial begin
        logic [15:0] ax, ay, bx, by, k;
        int settle;
        n_errors    = 0;
        idle_cycles = 0;
        quiet       = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: ordinary, right-angle, negative area, collinear, coincident
        send_triangle(pack_tri(0, 0, 4, 0, 0, 4));
        send_triangle(pack_tri(0, 0, 0, 4, 4, 0));
        send_triangle(pack_tri(1, 1, 2, 2, 3, 3));
        send_triangle(pack_tri(5, 5, 5, 5, 5, 5));
        send_triangle(pack_tri(0, 0, 0, 0, 7, 3));
        send_triangle(pack_tri(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
        send_triangle(pack_tri(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_triangle(pack_tri(16'hFFFF, 16'hFFFF, 0, 0, 1, 2));
        send_triangle(pack_tri(1, 2, 3, 5, 7, 11));
        // one exactly collinear, then nearly collinear: huge center, saturates both signs
        send_triangle(pack_tri(16'h8000, 16'h8000, 0, 0, 16'h7FFF, 16'h7FFF));
        send_triangle(pack_tri(16'h8000, 16'h8000, 0, 1, 16'h7FFF, 16'h7FFF));
        send_triangle(pack_tri(16'h8000, 16'h7FFF, 0, 0, 16'h7FFF, 16'h8000));
        send_triangle(pack_tri(16'h8000, 16'h7FFF, 1, 0, 16'h7FFF, 16'h8000));
        send_triangle(pack_tri(0, 0, 1, 0, 0, 1));
        send_triangle(pack_tri(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i > N_RANDOM - 120) quiet = 1;
            ax = rand_coord();
            ay = rand_coord();
            bx = rand_coord();
            by = rand_coord();
            case ($urandom_range(0, 7))
                // collinear along a random step
                0: begin
                    k = 16'($urandom_range(0, 3));
                    send_triangle(pack_tri(ax, ay, bx, by,
                                           16'(bx + k * (bx - ax)), 16'(by + k * (by - ay))));
                end
                // tiny slivers near collinear
                1: send_triangle(pack_tri(ax, ay, bx, by, 16'(2 * bx - ax + 1), 16'(2 * by - ay)));
                default: send_triangle(pack_tri(ax, ay, bx, by, rand_coord(), rand_coord()));
            endcase
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        settle = 0;
        while (settle < PIPE_LAT + 10) begin
            @(posedge aclk);
            settle++;
        end

        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
